// File: design/pulse_arc_fault_monitor_assert.svh
// Assertion macros for the arc fault monitor.
`ifndef PULSE_ARC_FAULT_MONITOR_ASSERT_SVH
`define PULSE_ARC_FAULT_MONITOR_ASSERT_SVH

// Checked on every rising edge, ignored while reset is asserted.
`define PAFM_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Checked on every rising edge, reset included.
`define PAFM_ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: design/pafm_pkg.sv
package pafm_pkg;

	localparam int unsigned CntW = 16;
	localparam int unsigned CfgIdxW = 3;
	localparam int unsigned FilterShiftDef = 6;

	typedef enum logic [1:0] {
		ACT_PULSE  = 2'd0,
		ACT_TICK   = 2'd1,
		ACT_UNTRIG = 2'd2,
		ACT_CLEAR  = 2'd3
	} act_t;

	typedef enum logic [CfgIdxW-1:0] {
		CFG_FAST_LEAK  = 3'd0,
		CFG_SLOW_LEAK  = 3'd1,
		CFG_FAST_LIMIT = 3'd2,
		CFG_SLOW_LIMIT = 3'd3,
		CFG_RUN_LIMIT  = 3'd4,
		CFG_FALSE_LEAK = 3'd5,
		CFG_FALSE_LIM  = 3'd6,
		CFG_SPARE      = 3'd7
	} cfg_idx_t;

	localparam logic [CntW-1:0] RstFastLeak  = 16'd100;
	localparam logic [CntW-1:0] RstSlowLeak  = 16'd10000;
	localparam logic [CntW-1:0] RstFastLimit = 16'd50;
	localparam logic [CntW-1:0] RstSlowLimit = 16'd200;
	localparam logic [CntW-1:0] RstRunLimit  = 16'd5;
	localparam logic [CntW-1:0] RstFalseLeak = 16'd100;
	localparam logic [CntW-1:0] RstFalseLim  = 16'd10;

	localparam int unsigned FltFast  = 0;
	localparam int unsigned FltSlow  = 1;
	localparam int unsigned FltRun   = 2;
	localparam int unsigned FltFalse = 3;

	localparam int unsigned FiltIntLow  = 0;
	localparam int unsigned FiltExtLow  = 1;
	localparam int unsigned FiltIntHigh = 2;
	localparam int unsigned FiltExtHigh = 3;

	function automatic logic [CntW-1:0] sat_inc(input logic [CntW-1:0] v);
		return (&v) ? v : v + 1'b1;
	endfunction

	function automatic logic [CntW-1:0] floor_dec(input logic [CntW-1:0] v);
		return (v != '0) ? v - 1'b1 : v;
	endfunction

endpackage

// File: design/pulse_arc_fault_monitor.sv
// Channel   | Direction | Handshake              | Payload
// ----------+-----------+------------------------+-----------------------------------------
// input     | in        | in_valid / in_ready    | action, latches, energy, two currents
// result    | out       | out_valid / out_ready  | arc flag, fault flags, counters, filters
// config    | in        | cfg_we (no wait)       | cfg_index, cfg_data
//
// Each word passes through the input register, then the counter and filter update loads the
// state and the result register together.
// One word is accepted every cycle unless a result stalls; the input register refills while
// the result is taken. A stalled result holds the input register full, and in_ready falls.
// Reset clears all counters, tallies, fault flags and filters and restores register defaults.
module pulse_arc_fault_monitor
	import pafm_pkg::*;
#(
	parameter int unsigned FILTER_SHIFT = FilterShiftDef
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic [1:0]          action,
	input  logic                over_latch,
	input  logic                within_latch,
	input  logic                energy_high,
	input  logic [CntW-1:0]     int_current,
	input  logic [CntW-1:0]     ext_current,
	output logic                out_valid,
	input  logic                out_ready,
	output logic                arc_detected,
	output logic [3:0]          fault_flags,
	output logic [CntW-1:0]     fast_count,
	output logic [CntW-1:0]     slow_count,
	output logic [CntW-1:0]     run_count,
	output logic [CntW-1:0]     false_count,
	output logic [CntW-1:0]     filt_int_low,
	output logic [CntW-1:0]     filt_ext_low,
	output logic [CntW-1:0]     filt_int_high,
	output logic [CntW-1:0]     filt_ext_high,
	input  logic                cfg_we,
	input  logic [CfgIdxW-1:0]  cfg_index,
	input  logic [CntW-1:0]     cfg_data
);

	`include "pulse_arc_fault_monitor_assert.svh"

	localparam int unsigned AccW = CntW + FILTER_SHIFT;

	// Configuration registers.
	logic [CntW-1:0] fast_leak_q, slow_leak_q, fast_limit_q, slow_limit_q;
	logic [CntW-1:0] run_limit_q, false_leak_q, false_lim_q;

	// Input register.
	logic            valid_s1;
	act_t            action_s1;
	logic            over_s1, within_s1, high_s1;
	logic [CntW-1:0] icur_s1, ecur_s1;

	// State, which also serves as the result register.
	logic            valid_s2;
	logic            arc_s2;
	logic [CntW-1:0] fast_q, slow_q, run_q, fast_tally_q, slow_tally_q;
	logic [CntW-1:0] false_q, tick_q;
	logic [3:0]      fault_q;
	logic [CntW-1:0] filt_q [4];

	logic            load_s2;
	logic            arc_d;
	logic [CntW-1:0] fast_d, slow_d, run_d, fast_tally_d, slow_tally_d, false_d, tick_d;
	logic [3:0]      fault_d;
	logic [CntW-1:0] filt_d [4];

	function automatic logic [CntW-1:0] rc_step(input logic [CntW-1:0] prev,
		input logic [CntW-1:0] reading);
		logic [AccW-1:0] acc;
		acc = {prev, {FILTER_SHIFT{1'b0}}} - AccW'(prev) + AccW'(reading);
		return acc[FILTER_SHIFT +: CntW];
	endfunction

	assign load_s2  = valid_s1 && (!valid_s2 || out_ready);
	assign in_ready = !valid_s1 || load_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fast_leak_q  <= RstFastLeak;
			slow_leak_q  <= RstSlowLeak;
			fast_limit_q <= RstFastLimit;
			slow_limit_q <= RstSlowLimit;
			run_limit_q  <= RstRunLimit;
			false_leak_q <= RstFalseLeak;
			false_lim_q  <= RstFalseLim;
		end else if (cfg_we) begin
			unique case (cfg_idx_t'(cfg_index))
				CFG_FAST_LEAK:  fast_leak_q  <= cfg_data;
				CFG_SLOW_LEAK:  slow_leak_q  <= cfg_data;
				CFG_FAST_LIMIT: fast_limit_q <= cfg_data;
				CFG_SLOW_LIMIT: slow_limit_q <= cfg_data;
				CFG_RUN_LIMIT:  run_limit_q  <= cfg_data;
				CFG_FALSE_LEAK: false_leak_q <= cfg_data;
				CFG_FALSE_LIM:  false_lim_q  <= cfg_data;
				CFG_SPARE:      ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			action_s1 <= act_t'(action);
			over_s1   <= over_latch;
			within_s1 <= within_latch;
			high_s1   <= energy_high;
			icur_s1   <= int_current;
			ecur_s1   <= ext_current;
		end
	end

	always_comb begin
		logic [CntW:0] fast_next, slow_next, tick_next;
		logic          fast_wrap, slow_wrap;
		logic [1:0]    base;

		arc_d        = 1'b0;
		fast_d       = fast_q;
		slow_d       = slow_q;
		run_d        = run_q;
		fast_tally_d = fast_tally_q;
		slow_tally_d = slow_tally_q;
		false_d      = false_q;
		tick_d       = tick_q;
		fault_d      = fault_q;
		for (int i = 0; i < 4; i++) begin
			filt_d[i] = filt_q[i];
		end

		fast_next = {1'b0, fast_tally_q} + 1'b1;
		slow_next = {1'b0, slow_tally_q} + 1'b1;
		tick_next = {1'b0, tick_q} + 1'b1;
		fast_wrap = fast_next > {1'b0, fast_leak_q};
		slow_wrap = slow_next > {1'b0, slow_leak_q};
		base      = {high_s1, 1'b0};

		unique case (action_s1)
			ACT_PULSE: begin
				arc_d = over_s1 || !within_s1;
				// Increment on an arc first, then apply the leak to the same count.
				fast_d = arc_d ? sat_inc(fast_q) : fast_q;
				slow_d = arc_d ? sat_inc(slow_q) : slow_q;
				run_d  = arc_d ? sat_inc(run_q) : floor_dec(run_q);
				if (fast_wrap) begin
					fast_d = floor_dec(fast_d);
				end
				if (slow_wrap) begin
					slow_d = floor_dec(slow_d);
				end
				fast_tally_d = fast_wrap ? '0 : fast_next[CntW-1:0];
				slow_tally_d = slow_wrap ? '0 : slow_next[CntW-1:0];
				fault_d[FltFast] = fault_q[FltFast] || (fast_d >= fast_limit_q);
				fault_d[FltSlow] = fault_q[FltSlow] || (slow_d >= slow_limit_q);
				fault_d[FltRun]  = fault_q[FltRun] || (run_d >= run_limit_q);
				if (!arc_d) begin
					filt_d[base]        = rc_step(filt_q[base], icur_s1);
					filt_d[base + 2'd1] = rc_step(filt_q[base + 2'd1], ecur_s1);
				end
			end
			ACT_TICK: begin
				// A leak period of zero behaves as one, since the tally is never below one here.
				if (tick_next >= {1'b0, false_leak_q}) begin
					tick_d  = '0;
					false_d = floor_dec(false_q);
				end else begin
					tick_d = tick_next[CntW-1:0];
				end
				fault_d[FltFalse] = fault_q[FltFalse] || (false_d >= false_lim_q);
			end
			ACT_UNTRIG: begin
				false_d = sat_inc(false_q);
			end
			ACT_CLEAR: begin
				fast_d       = '0;
				slow_d       = '0;
				run_d        = '0;
				fast_tally_d = '0;
				slow_tally_d = '0;
				false_d      = '0;
				fault_d      = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2     <= 1'b0;
			arc_s2       <= 1'b0;
			fast_q       <= '0;
			slow_q       <= '0;
			run_q        <= '0;
			fast_tally_q <= '0;
			slow_tally_q <= '0;
			false_q      <= '0;
			tick_q       <= '0;
			fault_q      <= '0;
			for (int i = 0; i < 4; i++) begin
				filt_q[i] <= '0;
			end
		end else begin
			if (load_s2) begin
				valid_s2 <= 1'b1;
			end else if (out_ready) begin
				valid_s2 <= 1'b0;
			end
			if (load_s2) begin
				arc_s2       <= arc_d;
				fast_q       <= fast_d;
				slow_q       <= slow_d;
				run_q        <= run_d;
				fast_tally_q <= fast_tally_d;
				slow_tally_q <= slow_tally_d;
				false_q      <= false_d;
				tick_q       <= tick_d;
				fault_q      <= fault_d;
				for (int i = 0; i < 4; i++) begin
					filt_q[i] <= filt_d[i];
				end
			end
		end
	end

	assign out_valid     = valid_s2;
	assign arc_detected  = arc_s2;
	assign fault_flags   = fault_q;
	assign fast_count    = fast_q;
	assign slow_count    = slow_q;
	assign run_count     = run_q;
	assign false_count   = false_q;
	assign filt_int_low  = filt_q[FiltIntLow];
	assign filt_ext_low  = filt_q[FiltExtLow];
	assign filt_int_high = filt_q[FiltIntHigh];
	assign filt_ext_high = filt_q[FiltExtHigh];

	`PAFM_ASSERT(a_arc_runs, out_valid && arc_detected |-> run_count != '0, "arc with zero run count")
	`PAFM_ASSERT(a_fault_sticky, load_s2 && action_s1 != ACT_CLEAR |=> (fault_q & $past(fault_q)) == $past(fault_q), "fault flag dropped without clear")
	`PAFM_ASSERT_ALWAYS(a_ready_stall, !in_ready |-> valid_s1 && valid_s2 && !out_ready, "input stalled without a held result")

endmodule

// File: tb/sv/tb.sv
module tb;
	import pafm_pkg::*;

	localparam int CYCLE_LIMIT = 1_000_000;
	localparam int FSH = FilterShiftDef;

	typedef struct packed {
		act_t            act;
		logic            over;
		logic            in_range;
		logic            high;
		logic [CntW-1:0] icur;
		logic [CntW-1:0] ecur;
	} in_word_t;

	typedef struct packed {
		logic            arc;
		logic [3:0]      flags;
		logic [CntW-1:0] fast_cnt;
		logic [CntW-1:0] slow_cnt;
		logic [CntW-1:0] run_cnt;
		logic [CntW-1:0] false_cnt;
		logic [CntW-1:0] int_lo;
		logic [CntW-1:0] ext_lo;
		logic [CntW-1:0] int_hi;
		logic [CntW-1:0] ext_hi;
	} res_t;

	typedef struct packed {
		in_word_t stim;
		logic     typed;
		res_t     want;
	} row_t;

	typedef logic [CntW-1:0] reg_set_t [CFG_FAST_LEAK:CFG_FALSE_LIM];

	logic            clk;
	logic            arst_n;
	logic            in_valid;
	logic            in_ready;
	logic [1:0]      action;
	logic            over_latch;
	logic            within_latch;
	logic            energy_high;
	logic [CntW-1:0] int_current;
	logic [CntW-1:0] ext_current;
	logic            out_valid;
	logic            out_ready;
	logic            arc_detected;
	logic [3:0]      fault_flags;
	logic [CntW-1:0] fast_count;
	logic [CntW-1:0] slow_count;
	logic [CntW-1:0] run_count;
	logic [CntW-1:0] false_count;
	logic [CntW-1:0] filt_int_low;
	logic [CntW-1:0] filt_ext_low;
	logic [CntW-1:0] filt_int_high;
	logic [CntW-1:0] filt_ext_high;
	logic            cfg_we;
	logic [CfgIdxW-1:0] cfg_index;
	logic [CntW-1:0] cfg_data;

	pulse_arc_fault_monitor dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.action(action), .over_latch(over_latch), .within_latch(within_latch),
		.energy_high(energy_high), .int_current(int_current), .ext_current(ext_current),
		.out_valid(out_valid), .out_ready(out_ready),
		.arc_detected(arc_detected), .fault_flags(fault_flags),
		.fast_count(fast_count), .slow_count(slow_count),
		.run_count(run_count), .false_count(false_count),
		.filt_int_low(filt_int_low), .filt_ext_low(filt_ext_low),
		.filt_int_high(filt_int_high), .filt_ext_high(filt_ext_high),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	// Mirror of the block's registers and counters.
	reg_set_t        reg_val = '{RstFastLeak, RstSlowLeak, RstFastLimit, RstSlowLimit,
		RstRunLimit, RstFalseLeak, RstFalseLim};
	logic [CntW-1:0] arcs_fast = '0;
	logic [CntW-1:0] arcs_slow = '0;
	logic [CntW-1:0] arcs_run = '0;
	logic [CntW-1:0] tally_fast = '0;
	logic [CntW-1:0] tally_slow = '0;
	logic [CntW-1:0] false_trig = '0;
	logic [CntW-1:0] tick_tally = '0;
	logic [3:0]      faults = '0;
	logic [CntW-1:0] filt [4] = '{'0, '0, '0, '0};

	res_t pending_results [$];
	res_t want_res;
	int   error_count = 0;
	int   cycle_count = 0;
	bit   idle_on = 1'b1;

	// Directed words, with the result typed in where it is plain to see.
	row_t dir_rows [19] = '{
		'{'{ACT_TICK, 1'b0, 1'b0, 1'b0, 16'h0000, 16'h0000}, 1'b1,
			'{1'b0, 4'h0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0}},
		'{'{ACT_PULSE, 1'b0, 1'b1, 1'b0, 16'hFFFF, 16'hFFFF}, 1'b1,
			'{1'b0, 4'h0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd1023, 16'd1023, 16'd0, 16'd0}},
		'{'{ACT_PULSE, 1'b1, 1'b1, 1'b1, 16'h0000, 16'h0000}, 1'b1,
			'{1'b1, 4'h0, 16'd1, 16'd1, 16'd1, 16'd0, 16'd1023, 16'd1023, 16'd0, 16'd0}},
		'{'{ACT_PULSE, 1'b0, 1'b0, 1'b0, 16'hFFFF, 16'h0000}, 1'b1,
			'{1'b1, 4'h0, 16'd2, 16'd2, 16'd2, 16'd0, 16'd1023, 16'd1023, 16'd0, 16'd0}},
		'{'{ACT_PULSE, 1'b1, 1'b0, 1'b1, 16'hFFFF, 16'hFFFF}, 1'b1,
			'{1'b1, 4'h0, 16'd3, 16'd3, 16'd3, 16'd0, 16'd1023, 16'd1023, 16'd0, 16'd0}},
		'{'{ACT_PULSE, 1'b0, 1'b1, 1'b1, 16'hFFFF, 16'h0000}, 1'b1,
			'{1'b0, 4'h0, 16'd3, 16'd3, 16'd2, 16'd0, 16'd1023, 16'd1023, 16'd1023, 16'd0}},
		'{'{ACT_UNTRIG, 1'b1, 1'b1, 1'b1, 16'hFFFF, 16'hFFFF}, 1'b1,
			'{1'b0, 4'h0, 16'd3, 16'd3, 16'd2, 16'd1, 16'd1023, 16'd1023, 16'd1023, 16'd0}},
		'{'{ACT_CLEAR, 1'b0, 1'b0, 1'b0, 16'h0000, 16'h0000}, 1'b1,
			'{1'b0, 4'h0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd1023, 16'd1023, 16'd1023, 16'd0}},
		'{'{ACT_PULSE, 1'b1, 1'b1, 1'b0, 16'h1234, 16'h4321}, 1'b0, '0},
		'{'{ACT_PULSE, 1'b1, 1'b1, 1'b0, 16'h1234, 16'h4321}, 1'b0, '0},
		'{'{ACT_PULSE, 1'b1, 1'b1, 1'b0, 16'h1234, 16'h4321}, 1'b0, '0},
		'{'{ACT_PULSE, 1'b1, 1'b1, 1'b0, 16'h1234, 16'h4321}, 1'b0, '0},
		'{'{ACT_PULSE, 1'b1, 1'b1, 1'b0, 16'h1234, 16'h4321}, 1'b1,
			'{1'b1, 4'(1 << FltRun), 16'd5, 16'd5, 16'd5, 16'd0,
			16'd1023, 16'd1023, 16'd1023, 16'd0}},
		'{'{ACT_PULSE, 1'b0, 1'b1, 1'b0, 16'd1000, 16'd2000}, 1'b0, '0},
		'{'{ACT_UNTRIG, 1'b0, 1'b0, 1'b0, 16'h0000, 16'h0000}, 1'b0, '0},
		'{'{ACT_TICK, 1'b1, 1'b1, 1'b1, 16'hFFFF, 16'hFFFF}, 1'b0, '0},
		'{'{ACT_PULSE, 1'b0, 1'b1, 1'b1, 16'd40000, 16'd50}, 1'b0, '0},
		'{'{ACT_CLEAR, 1'b1, 1'b1, 1'b1, 16'hFFFF, 16'hFFFF}, 1'b0, '0},
		'{'{ACT_PULSE, 1'b0, 1'b0, 1'b1, 16'h0000, 16'hFFFF}, 1'b0, '0}
	};

	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	function automatic logic [CntW-1:0] sat_up(input logic [CntW-1:0] v);
		return (v == '1) ? v : v + 1'b1;
	endfunction

	function automatic logic [CntW-1:0] floor_down(input logic [CntW-1:0] v);
		return (v == '0) ? v : v - 1'b1;
	endfunction

	function automatic logic [CntW-1:0] smooth(input logic [CntW-1:0] prev,
		input logic [CntW-1:0] reading);
		logic [31:0] acc;
		acc = 32'(prev) * ((32'd1 << FSH) - 32'd1) + 32'(reading);
		return CntW'(acc >> FSH);
	endfunction

	// Advances a pulse tally; true when the counter it guards is due to leak.
	function automatic bit leak_due(inout logic [CntW-1:0] tally,
		input logic [CntW-1:0] interval);
		logic [CntW:0] nxt;
		nxt = {1'b0, tally} + 1'b1;
		if (nxt > {1'b0, interval}) begin
			tally = '0;
			return 1'b1;
		end
		tally = nxt[CntW-1:0];
		return 1'b0;
	endfunction

	function automatic res_t judge_word(input in_word_t w);
		res_t       r;
		logic       arc;
		logic [CntW:0] nxt;
		arc = 1'b0;
		case (w.act)
			ACT_PULSE: begin
				arc = w.over || !w.in_range;
				if (arc) begin
					arcs_fast = sat_up(arcs_fast);
					arcs_slow = sat_up(arcs_slow);
					arcs_run = sat_up(arcs_run);
				end else begin
					arcs_run = floor_down(arcs_run);
				end
				if (leak_due(tally_fast, reg_val[CFG_FAST_LEAK]))
					arcs_fast = floor_down(arcs_fast);
				if (leak_due(tally_slow, reg_val[CFG_SLOW_LEAK]))
					arcs_slow = floor_down(arcs_slow);
				if (arcs_fast >= reg_val[CFG_FAST_LIMIT]) faults[FltFast] = 1'b1;
				if (arcs_slow >= reg_val[CFG_SLOW_LIMIT]) faults[FltSlow] = 1'b1;
				if (arcs_run >= reg_val[CFG_RUN_LIMIT]) faults[FltRun] = 1'b1;
				if (!arc && w.high) begin
					filt[FiltIntHigh] = smooth(filt[FiltIntHigh], w.icur);
					filt[FiltExtHigh] = smooth(filt[FiltExtHigh], w.ecur);
				end else if (!arc) begin
					filt[FiltIntLow] = smooth(filt[FiltIntLow], w.icur);
					filt[FiltExtLow] = smooth(filt[FiltExtLow], w.ecur);
				end
			end
			ACT_TICK: begin
				// A leak setting of zero leaks on every tick, as does one.
				nxt = {1'b0, tick_tally} + 1'b1;
				if (nxt >= {1'b0, reg_val[CFG_FALSE_LEAK]}) begin
					tick_tally = '0;
					false_trig = floor_down(false_trig);
				end else begin
					tick_tally = nxt[CntW-1:0];
				end
				if (false_trig >= reg_val[CFG_FALSE_LIM]) faults[FltFalse] = 1'b1;
			end
			ACT_UNTRIG: false_trig = sat_up(false_trig);
			default: begin
				// The tick tally and the filters survive a clear.
				arcs_fast = '0;
				arcs_slow = '0;
				arcs_run = '0;
				tally_fast = '0;
				tally_slow = '0;
				false_trig = '0;
				faults = '0;
			end
		endcase
		r.arc = arc;
		r.flags = faults;
		r.fast_cnt = arcs_fast;
		r.slow_cnt = arcs_slow;
		r.run_cnt = arcs_run;
		r.false_cnt = false_trig;
		r.int_lo = filt[FiltIntLow];
		r.ext_lo = filt[FiltExtLow];
		r.int_hi = filt[FiltIntHigh];
		r.ext_hi = filt[FiltExtHigh];
		return r;
	endfunction

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55) return 0;
		if (r < 88) return $urandom_range(1, 3);
		if (r < 97) return $urandom_range(4, 10);
		return $urandom_range(20, 40);
	endfunction

	function automatic logic [CntW-1:0] rand_current();
		case ($urandom_range(0, 9))
			0: return '0;
			1: return '1;
			default: return CntW'($urandom);
		endcase
	endfunction

	function automatic in_word_t rand_word(input int arc_pct);
		in_word_t w;
		int       r;
		w.over = 1'($urandom_range(0, 1));
		w.in_range = 1'($urandom_range(0, 1));
		w.high = 1'($urandom_range(0, 1));
		w.icur = rand_current();
		w.ecur = rand_current();
		r = $urandom_range(0, 99);
		if (r < 64) begin
			w.act = ACT_PULSE;
			if ($urandom_range(0, 99) < arc_pct) begin
				if (!w.over && w.in_range) begin
					if ($urandom_range(0, 1)) w.over = 1'b1;
					else w.in_range = 1'b0;
				end
			end else begin
				w.over = 1'b0;
				w.in_range = 1'b1;
			end
		end else if (r < 80) begin
			w.act = ACT_TICK;
		end else if (r < 96) begin
			w.act = ACT_UNTRIG;
		end else begin
			w.act = ACT_CLEAR;
		end
		return w;
	endfunction

	task automatic flag_error(input string msg);
		// Printing stops after a hundred lines; counting does not.
		if (error_count < 100) $display("mismatch at %0t: %s", $time, msg);
		error_count++;
	endtask

	task automatic check_field(input string name, input logic [CntW-1:0] got,
		input logic [CntW-1:0] want);
		if (got !== want) flag_error($sformatf("%s is %0h, expected %0h", name, got, want));
	endtask

	task automatic send_word(input in_word_t w, input logic typed, input res_t want);
		int   gap;
		res_t guess;
		gap = idle_on ? pick_gap() : 0;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		action <= w.act;
		over_latch <= w.over;
		within_latch <= w.in_range;
		energy_high <= w.high;
		int_current <= w.icur;
		ext_current <= w.ecur;
		do @(posedge clk); while (!in_ready);
		guess = judge_word(w);
		pending_results.push_back(typed ? want : guess);
	endtask

	task automatic wait_idle();
		in_valid <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
	endtask

	task automatic load_regs(input reg_set_t v);
		// The spare index must be ignored by the block.
		cfg_we <= 1'b1;
		cfg_index <= CFG_SPARE;
		cfg_data <= CntW'($urandom);
		@(posedge clk);
		for (int i = CFG_FAST_LEAK; i <= CFG_FALSE_LIM; i++) begin
			cfg_index <= cfg_idx_t'(i);
			cfg_data <= v[i];
			reg_val[i] = v[i];
			@(posedge clk);
		end
		cfg_we <= 1'b0;
	endtask

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			if (pending_results.size() == 0) begin
				flag_error("result word with no expectation waiting");
			end else begin
				want_res = pending_results.pop_front();
				check_field("arc_detected", CntW'(arc_detected), CntW'(want_res.arc));
				check_field("fault_flags", CntW'(fault_flags), CntW'(want_res.flags));
				check_field("fast_count", fast_count, want_res.fast_cnt);
				check_field("slow_count", slow_count, want_res.slow_cnt);
				check_field("run_count", run_count, want_res.run_cnt);
				check_field("false_count", false_count, want_res.false_cnt);
				check_field("filt_int_low", filt_int_low, want_res.int_lo);
				check_field("filt_ext_low", filt_ext_low, want_res.ext_lo);
				check_field("filt_int_high", filt_int_high, want_res.int_hi);
				check_field("filt_ext_high", filt_ext_high, want_res.ext_hi);
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	// Result side: stalls of random length between runs of readiness.
	initial begin
		int n;
		out_ready <= 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			n = idle_on ? pick_gap() : 0;
			if (n > 0) begin
				out_ready <= 1'b0;
				repeat (n) @(posedge clk);
			end
			out_ready <= 1'b1;
			repeat ($urandom_range(1, 12)) @(posedge clk);
		end
	end

	initial begin
		reg_set_t vals;
		in_word_t w;
		int       arc_pct;
		arst_n <= 1'b0;
		in_valid <= 1'b0;
		action <= ACT_PULSE;
		over_latch <= 1'b0;
		within_latch <= 1'b0;
		energy_high <= 1'b0;
		int_current <= '0;
		ext_current <= '0;
		cfg_we <= 1'b0;
		cfg_index <= CFG_FAST_LEAK;
		cfg_data <= '0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (dir_rows[i]) send_word(dir_rows[i].stim, dir_rows[i].typed, dir_rows[i].want);

		arc_pct = 50;
		for (int p = 0; p < 5; p++) begin
			wait_idle();
			case (p)
				0: vals = '{16'd3, 16'd7, 16'd4, 16'd6, 16'd3, 16'd2, 16'd3};
				1: vals = '{16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0};
				2: vals = '{16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF};
				3: foreach (vals[k]) vals[k] = CntW'($urandom_range(0, 12));
				default: vals = '{RstFastLeak, RstSlowLeak, RstFastLimit, RstSlowLimit,
					RstRunLimit, RstFalseLeak, RstFalseLim};
			endcase
			idle_on = (p != 3);
			load_regs(vals);
			for (int n = 0; n < 120; n++) begin
				// Bursts of mostly arcs or mostly clean pulses build up and drain the run counter.
				if (n % 20 == 0) begin
					case ($urandom_range(0, 2))
						0: arc_pct = 10;
						1: arc_pct = 50;
						default: arc_pct = 90;
					endcase
				end
				send_word(rand_word(arc_pct), 1'b0, '0);
			end
		end

		// Top limits and the longest leak intervals under arcs alternating with untriggered pulses, sent back to back.
		wait_idle();
		idle_on = 1'b0;
		vals = '{16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF};
		load_regs(vals);
		w = '0;
		w.act = ACT_CLEAR;
		send_word(w, 1'b0, '0);
		for (int n = 0; n < 10; n++) begin
			w = rand_word(100);
			w.act = ACT_PULSE;
			w.over = 1'b1;
			send_word(w, 1'b0, '0);
			w.act = ACT_UNTRIG;
			send_word(w, 1'b0, '0);
		end
		idle_on = 1'b1;
		for (int n = 0; n < 20; n++) begin
			w = rand_word(0);
			w.act = (n % 2) ? ACT_TICK : ACT_PULSE;
			send_word(w, 1'b0, '0);
		end

		wait_idle();
		repeat (10) @(posedge clk);
		if (error_count == 0 && pending_results.size() == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule

// File: sim.f
+incdir+design
design/pafm_pkg.sv
design/pulse_arc_fault_monitor.sv
tb/sv/tb.sv
